// ----- hw/rtl/rect_to_pair_search_trapezoids_defines.svh -----
// Assertion macros used by the checker file of the trapezoid block.
`ifndef RECT_TO_PAIR_SEARCH_TRAPEZOIDS_DEFINES_SVH
`define RECT_TO_PAIR_SEARCH_TRAPEZOIDS_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RTSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RTSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/rtsp_pkg.sv -----
// Types, constants and helper functions of the trapezoid search block.
`timescale 1ns / 1ps
package rtsp_pkg;

  localparam int CW    = 16;  // corner coordinate width
  localparam int OW    = 20;  // output vertex width
  localparam int GW    = 6;   // gain register width
  localparam int SW    = 17;  // midpoint sum width
  localparam int DW    = 18;  // midpoint difference width
  localparam int EW    = 24;  // width offset width
  localparam int TW    = 28;  // far vertex width before rounding
  localparam int RADW  = 44;  // square root radicand width
  localparam int ROOTW = RADW / 2;
  localparam int PW    = GW + ROOTW;
  localparam int MW    = PW + SW;
  localparam int QW    = 24;  // quotient width
  localparam int PLDLY = ROOTW + 2 + QW;
  localparam int NST   = 4 + ROOTW + 2 + QW + 1;

  localparam logic [GW-1:0] LengthGainRst = 6'd10;
  localparam logic [GW-1:0] WidthGainRst  = 6'd6;
  localparam logic signed [TW-1:0] HiLim = 28'sd524287;
  localparam logic signed [TW-1:0] LoLim = -28'sd524288;

  typedef enum logic [0:0] {
    CFG_LENGTH_GAIN = 1'b0,
    CFG_WIDTH_GAIN  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [CW-1:0] corner0_x;
    logic [CW-1:0] corner0_y;
    logic [CW-1:0] corner1_x;
    logic [CW-1:0] corner1_y;
    logic [CW-1:0] corner2_x;
    logic [CW-1:0] corner2_y;
    logic [CW-1:0] corner3_x;
    logic [CW-1:0] corner3_y;
  } rect_t;

  typedef struct packed {
    logic                 side;
    logic                 last;
    logic                 degenerate;
    logic signed [OW-1:0] vertex0_x;
    logic signed [OW-1:0] vertex0_y;
    logic signed [OW-1:0] vertex1_x;
    logic signed [OW-1:0] vertex1_y;
    logic signed [OW-1:0] vertex2_x;
    logic signed [OW-1:0] vertex2_y;
    logic signed [OW-1:0] vertex3_x;
    logic signed [OW-1:0] vertex3_y;
  } trap_t;

  // Per-rectangle data that rides along the root and divide pipelines.
  typedef struct packed {
    logic [CW-1:0]        ca_x;
    logic [CW-1:0]        ca_y;
    logic [CW-1:0]        cb_x;
    logic [CW-1:0]        cb_y;
    logic [CW-1:0]        cc_x;
    logic [CW-1:0]        cc_y;
    logic [CW-1:0]        cd_x;
    logic [CW-1:0]        cd_y;
    logic [SW-1:0]        s0_x;
    logic [SW-1:0]        s0_y;
    logic [SW-1:0]        s1_x;
    logic [SW-1:0]        s1_y;
    logic signed [DW-1:0] d_x;
    logic signed [DW-1:0] d_y;
    logic signed [EW-1:0] e0_x;
    logic signed [EW-1:0] e0_y;
    logic signed [EW-1:0] e1_x;
    logic signed [EW-1:0] e1_y;
    logic                 degen;
  } pl_t;

  // Far vertices in Q.5, left pair then right pair.
  typedef struct packed {
    logic signed [TW-1:0] l2_x;
    logic signed [TW-1:0] l2_y;
    logic signed [TW-1:0] l3_x;
    logic signed [TW-1:0] l3_y;
    logic signed [TW-1:0] r2_x;
    logic signed [TW-1:0] r2_y;
    logic signed [TW-1:0] r3_x;
    logic signed [TW-1:0] r3_y;
  } far_t;

  // Q.5 to Q.4 with ties toward +inf, then clamp to the output range.
  function automatic logic signed [OW-1:0] half_sat(input logic signed [TW-1:0] t);
    logic signed [TW:0]   u;
    logic signed [TW-1:0] h;
    u = {t[TW-1], t} + 1'sb1;
    h = u[TW:1];
    if (h > HiLim) begin
      h = HiLim;
    end else if (h < LoLim) begin
      h = LoLim;
    end
    return h[OW-1:0];
  endfunction

endpackage

// ----- hw/rtl/rtsp_stream_if.sv -----
// Valid/ready stream channel with a typed payload.
`timescale 1ns / 1ps
interface rtsp_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/rtsp_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module rtsp_isqrt #(
  parameter int W = 44
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [W-1:0]   rad_i,
  output logic [W/2-1:0] root_o
);
  localparam int R  = W / 2;
  localparam int RW = R + 2;
  localparam int XW = R + 4;

  logic [W-1:0]  rad_q  [R];
  logic [RW-1:0] rem_q  [R];
  logic [R-1:0]  root_q [R];

  for (genvar s = 0; s < R; s++) begin : g_st
    logic [W-1:0]  rad_p;
    logic [RW-1:0] rem_p;
    logic [R-1:0]  root_p;
    logic [XW-1:0] remx;
    logic [XW-1:0] trial;
    logic          ge;

    if (s == 0) begin : g_first
      assign rad_p  = rad_i;
      assign rem_p  = '0;
      assign root_p = '0;
    end else begin : g_next
      assign rad_p  = rad_q[s-1];
      assign rem_p  = rem_q[s-1];
      assign root_p = root_q[s-1];
    end

    assign remx  = {rem_p, rad_p[W-1 -: 2]};
    assign trial = XW'({root_p, 2'b01});
    assign ge    = remx >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[s]  <= {rad_p[W-3:0], 2'b00};
        rem_q[s]  <= ge ? RW'(remx - trial) : RW'(remx);
        root_q[s] <= {root_p[R-2:0], ge};
      end
    end
  end

  assign root_o = root_q[R-1];
endmodule

// ----- hw/rtl/rtsp_div.sv -----
// Pipelined rounded division (2m+ld)/(2ld), one quotient bit per stage.
`timescale 1ns / 1ps
module rtsp_div #(
  parameter int MW = 45,
  parameter int LW = 22,
  parameter int QW = 24
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [MW-1:0] m_i,
  input  logic [LW-1:0] ld_i,
  output logic [QW-1:0] q_o
);
  localparam int NW = MW + 1;
  localparam int DW = LW + 1;
  localparam int RW = DW + 1;
  localparam int XW = RW + 1;

  logic [NW-1:0] num;
  logic [DW-1:0] den;

  // Adding half the divisor gives round to nearest, ties away from zero.
  assign num = {m_i, 1'b0} + NW'(ld_i);
  assign den = {ld_i, 1'b0};

  logic [RW-1:0] rem_q [QW];
  logic [QW-1:0] lo_q  [QW];
  logic [QW-1:0] quo_q [QW];
  logic [DW-1:0] den_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_st
    logic [RW-1:0] rem_p;
    logic [QW-1:0] lo_p;
    logic [QW-1:0] quo_p;
    logic [DW-1:0] den_p;
    logic [XW-1:0] remx;
    logic          ge;

    if (s == 0) begin : g_first
      // Quotient fits QW bits, so the top part is already below the divisor.
      assign rem_p = RW'(num[NW-1:QW]);
      assign lo_p  = num[QW-1:0];
      assign quo_p = '0;
      assign den_p = den;
    end else begin : g_next
      assign rem_p = rem_q[s-1];
      assign lo_p  = lo_q[s-1];
      assign quo_p = quo_q[s-1];
      assign den_p = den_q[s-1];
    end

    assign remx = {rem_p, lo_p[QW-1]};
    assign ge   = remx >= XW'(den_p);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? RW'(remx - XW'(den_p)) : RW'(remx);
        lo_q[s]  <= {lo_p[QW-2:0], 1'b0};
        quo_q[s] <= {quo_p[QW-2:0], ge};
        den_q[s] <= den_p;
      end
    end
  end

  assign q_o = quo_q[QW-1];
endmodule

// ----- hw/rtl/rtsp_pair_out.sv -----
// Output register that holds one rectangle's two trapezoids and sends them in turn.
`timescale 1ns / 1ps
module rtsp_pair_out import rtsp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 vld_i,
  input  pl_t                  pl_i,
  input  far_t                 far_i,
  output logic                 take_o,
  rtsp_stream_if.source        trap_o
);
  logic  hv_q, ph_q;
  trap_t l_q, r_q;
  logic  load;

  // Take a new pair when empty or when the right item leaves this cycle.
  assign take_o = ~hv_q | (ph_q & trap_o.ready);
  assign load   = vld_i & take_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q <= 1'b0;
      ph_q <= 1'b0;
    end else if (load) begin
      hv_q <= 1'b1;
      ph_q <= 1'b0;
    end else if (hv_q && trap_o.ready) begin
      if (ph_q) begin
        hv_q <= 1'b0;
      end else begin
        ph_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      l_q.side       <= 1'b0;
      l_q.last       <= 1'b0;
      l_q.degenerate <= pl_i.degen;
      l_q.vertex0_x  <= OW'(pl_i.ca_x);
      l_q.vertex0_y  <= OW'(pl_i.ca_y);
      l_q.vertex1_x  <= OW'(pl_i.cb_x);
      l_q.vertex1_y  <= OW'(pl_i.cb_y);
      l_q.vertex2_x  <= half_sat(far_i.l2_x);
      l_q.vertex2_y  <= half_sat(far_i.l2_y);
      l_q.vertex3_x  <= half_sat(far_i.l3_x);
      l_q.vertex3_y  <= half_sat(far_i.l3_y);
      r_q.side       <= 1'b1;
      r_q.last       <= 1'b1;
      r_q.degenerate <= pl_i.degen;
      r_q.vertex0_x  <= OW'(pl_i.cc_x);
      r_q.vertex0_y  <= OW'(pl_i.cc_y);
      r_q.vertex1_x  <= OW'(pl_i.cd_x);
      r_q.vertex1_y  <= OW'(pl_i.cd_y);
      r_q.vertex2_x  <= half_sat(far_i.r2_x);
      r_q.vertex2_y  <= half_sat(far_i.r2_y);
      r_q.vertex3_x  <= half_sat(far_i.r3_x);
      r_q.vertex3_y  <= half_sat(far_i.r3_y);
    end
  end

  assign trap_o.valid = hv_q;
  assign trap_o.data  = ph_q ? r_q : l_q;
endmodule

// ----- hw/rtl/rect_to_pair_search_trapezoids.sv -----
// Top level: rotated rectangle in, left and right search trapezoids out.
//
//  channel    dir  payload   item
//  rect_in    in   rect_t    four corners, unsigned Q12.4
//  trap_out   out  trap_t    one trapezoid, signed Q16.4, two per rectangle
//  cfg_*      in   6 bits    length_gain (0), width_gain (1)
//
// A rectangle enters each cycle, unless stalled, into a 53-stage pipeline: four
// setup stages, 22 root stages (one bit each), two multiply stages, 24 divide
// stages, one far-vertex stage. The output register then sends the left
// trapezoid and, once it is taken, the right one; it takes a new rectangle only
// when empty or as the right item of the last one leaves. Reset clears valid
// bits and loads gains 10 and 6. A stalled output freezes the pipeline once its
// last stage holds an item; while that stage is empty, the pipeline advances.
`timescale 1ns / 1ps
module rect_to_pair_search_trapezoids import rtsp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_idx_i,
  input  logic [GW-1:0]        cfg_wdata_i,
  rtsp_stream_if.sink          rect_in,
  rtsp_stream_if.source        trap_out
);
  logic [GW-1:0] lg_q, wg_q;
  logic          en, take;
  logic          vld_q [NST];
  rect_t         r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_q <= LengthGainRst;
      wg_q <= WidthGainRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LENGTH_GAIN: lg_q <= cfg_wdata_i;
        CFG_WIDTH_GAIN:  wg_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign en            = ~vld_q[NST-1] | take;
  assign rect_in.ready = en;
  assign r             = rect_in.data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NST; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= rect_in.valid;
      for (int k = 1; k < NST; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // Stage A: side vectors squared.
  logic signed [SW-1:0] a1x, a1y, a2x, a2y;
  logic signed [33:0]   p1x, p1y, p2x, p2y;
  rect_t                a_c_q;
  logic [31:0]          a_s1x_q, a_s1y_q, a_s2x_q, a_s2y_q;

  assign a1x = $signed({1'b0, r.corner0_x}) - $signed({1'b0, r.corner1_x});
  assign a1y = $signed({1'b0, r.corner0_y}) - $signed({1'b0, r.corner1_y});
  assign a2x = $signed({1'b0, r.corner1_x}) - $signed({1'b0, r.corner2_x});
  assign a2y = $signed({1'b0, r.corner1_y}) - $signed({1'b0, r.corner2_y});
  assign p1x = a1x * a1x;
  assign p1y = a1y * a1y;
  assign p2x = a2x * a2x;
  assign p2y = a2y * a2y;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_c_q   <= r;
      a_s1x_q <= p1x[31:0];
      a_s1y_q <= p1y[31:0];
      a_s2x_q <= p2x[31:0];
      a_s2y_q <= p2y[31:0];
    end
  end

  // Stage B: pick the starting corner so that the first side is the longer one (ties keep corner 0).
  logic [32:0]   d1sq, d2sq;
  logic          i0;
  logic [CW-1:0] b_ax_q, b_ay_q, b_bx_q, b_by_q, b_cx_q, b_cy_q, b_dx_q, b_dy_q;
  logic [32:0]   b_msq_q;

  assign d1sq = {1'b0, a_s1x_q} + {1'b0, a_s1y_q};
  assign d2sq = {1'b0, a_s2x_q} + {1'b0, a_s2y_q};
  assign i0   = d1sq < d2sq;

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_msq_q <= i0 ? d2sq : d1sq;
      if (i0) begin
        b_ax_q <= a_c_q.corner1_x; b_ay_q <= a_c_q.corner1_y;
        b_bx_q <= a_c_q.corner2_x; b_by_q <= a_c_q.corner2_y;
        b_cx_q <= a_c_q.corner3_x; b_cy_q <= a_c_q.corner3_y;
        b_dx_q <= a_c_q.corner0_x; b_dy_q <= a_c_q.corner0_y;
      end else begin
        b_ax_q <= a_c_q.corner0_x; b_ay_q <= a_c_q.corner0_y;
        b_bx_q <= a_c_q.corner1_x; b_by_q <= a_c_q.corner1_y;
        b_cx_q <= a_c_q.corner2_x; b_cy_q <= a_c_q.corner2_y;
        b_dx_q <= a_c_q.corner3_x; b_dy_q <= a_c_q.corner3_y;
      end
    end
  end

  // Stage C: midpoint sums, their difference and width offsets.
  logic [SW-1:0]        s0x, s0y, s1x, s1y;
  logic signed [DW-1:0] ddx, ddy;
  logic signed [SW-1:0] bax, bay, dcx, dcy;
  logic signed [GW:0]   wg_s;
  logic signed [35:0]   qx, qy;
  pl_t                  c_pl_q;
  logic [33:0]          c_qx_q, c_qy_q;
  logic [32:0]          c_msq_q;

  assign s0x  = {1'b0, b_ax_q} + {1'b0, b_bx_q};
  assign s0y  = {1'b0, b_ay_q} + {1'b0, b_by_q};
  assign s1x  = {1'b0, b_cx_q} + {1'b0, b_dx_q};
  assign s1y  = {1'b0, b_cy_q} + {1'b0, b_dy_q};
  assign ddx  = $signed({1'b0, s1x}) - $signed({1'b0, s0x});
  assign ddy  = $signed({1'b0, s1y}) - $signed({1'b0, s0y});
  assign bax  = $signed({1'b0, b_bx_q}) - $signed({1'b0, b_ax_q});
  assign bay  = $signed({1'b0, b_by_q}) - $signed({1'b0, b_ay_q});
  assign dcx  = $signed({1'b0, b_dx_q}) - $signed({1'b0, b_cx_q});
  assign dcy  = $signed({1'b0, b_dy_q}) - $signed({1'b0, b_cy_q});
  assign wg_s = $signed({1'b0, wg_q});
  assign qx   = ddx * ddx;
  assign qy   = ddy * ddy;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_pl_q.ca_x  <= b_ax_q; c_pl_q.ca_y <= b_ay_q;
      c_pl_q.cb_x  <= b_bx_q; c_pl_q.cb_y <= b_by_q;
      c_pl_q.cc_x  <= b_cx_q; c_pl_q.cc_y <= b_cy_q;
      c_pl_q.cd_x  <= b_dx_q; c_pl_q.cd_y <= b_dy_q;
      c_pl_q.s0_x  <= s0x;    c_pl_q.s0_y <= s0y;
      c_pl_q.s1_x  <= s1x;    c_pl_q.s1_y <= s1y;
      c_pl_q.d_x   <= ddx;    c_pl_q.d_y  <= ddy;
      c_pl_q.e0_x  <= 24'sd2 * wg_s * bax;
      c_pl_q.e0_y  <= 24'sd2 * wg_s * bay;
      c_pl_q.e1_x  <= 24'sd2 * wg_s * dcx;
      c_pl_q.e1_y  <= 24'sd2 * wg_s * dcy;
      c_pl_q.degen <= 1'b0;
      c_qx_q       <= qx[33:0];
      c_qy_q       <= qy[33:0];
      c_msq_q      <= b_msq_q;
    end
  end

  // Stage D: squared length of the midpoint difference.
  logic [34:0] dsq;
  pl_t         d_pl;
  pl_t         d_pl_q;
  logic [34:0] d_dsq_q;
  logic [32:0] d_msq_q;

  assign dsq = {1'b0, c_qx_q} + {1'b0, c_qy_q};

  always_comb begin
    d_pl       = c_pl_q;
    d_pl.degen = dsq == '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_pl_q  <= d_pl;
      d_dsq_q <= dsq;
      d_msq_q <= c_msq_q;
    end
  end

  // Roots of both lengths, scaled by 16.
  logic [ROOTW-1:0] lm, ld;

  rtsp_isqrt #(.W(RADW)) u_sqrt_m (
    .clk_i (clk_i),
    .en_i  (en),
    .rad_i (RADW'({d_msq_q, 8'h00})),
    .root_o(lm)
  );

  rtsp_isqrt #(.W(RADW)) u_sqrt_d (
    .clk_i (clk_i),
    .en_i  (en),
    .rad_i (RADW'({d_dsq_q, 8'h00})),
    .root_o(ld)
  );

  pl_t pl_dly_q [PLDLY];

  always_ff @(posedge clk_i) begin
    if (en) begin
      pl_dly_q[0] <= d_pl_q;
      for (int k = 1; k < PLDLY; k++) pl_dly_q[k] <= pl_dly_q[k-1];
    end
  end

  // Multiply stages: gain times long side, then times |difference|.
  pl_t                  pm;
  logic signed [DW-1:0] ndx, ndy;
  logic [SW-1:0]        adx, ady;
  logic [PW-1:0]        m1_p;
  logic [PW-1:0]        m1_p_q;
  logic [SW-1:0]        m1_ax_q, m1_ay_q;
  logic [ROOTW-1:0]     m1_ld_q, m2_ld_q;
  logic [MW-1:0]        m2_x, m2_y, m2_x_q, m2_y_q;

  assign pm   = pl_dly_q[ROOTW-1];
  assign ndx  = -pm.d_x;
  assign ndy  = -pm.d_y;
  assign adx  = pm.d_x[DW-1] ? ndx[SW-1:0] : pm.d_x[SW-1:0];
  assign ady  = pm.d_y[DW-1] ? ndy[SW-1:0] : pm.d_y[SW-1:0];
  assign m1_p = lg_q * lm;
  assign m2_x = m1_p_q * m1_ax_q;
  assign m2_y = m1_p_q * m1_ay_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_p_q  <= m1_p;
      m1_ax_q <= adx;
      m1_ay_q <= ady;
      m1_ld_q <= ld;
      m2_x_q  <= m2_x;
      m2_y_q  <= m2_y;
      m2_ld_q <= m1_ld_q;
    end
  end

  logic [QW-1:0] quo_x, quo_y;

  rtsp_div #(.MW(MW), .LW(ROOTW), .QW(QW)) u_div_x (
    .clk_i(clk_i),
    .en_i (en),
    .m_i  (m2_x_q),
    .ld_i (m2_ld_q),
    .q_o  (quo_x)
  );

  rtsp_div #(.MW(MW), .LW(ROOTW), .QW(QW)) u_div_y (
    .clk_i(clk_i),
    .en_i (en),
    .m_i  (m2_y_q),
    .ld_i (m2_ld_q),
    .q_o  (quo_y)
  );

  // Far vertices in Q.5; a degenerate difference drops the reach vector.
  pl_t                  pf;
  logic signed [QW:0]   pqx, pqy, vx, vy;
  logic signed [TW-1:0] s0xs, s0ys, s1xs, s1ys;
  pl_t                  f_pl_q;
  far_t                 f_far_q;

  assign pf   = pl_dly_q[PLDLY-1];
  assign pqx  = $signed({1'b0, quo_x});
  assign pqy  = $signed({1'b0, quo_y});
  assign vx   = pf.degen ? '0 : (pf.d_x[DW-1] ? -pqx : pqx);
  assign vy   = pf.degen ? '0 : (pf.d_y[DW-1] ? -pqy : pqy);
  assign s0xs = $signed(TW'(pf.s0_x));
  assign s0ys = $signed(TW'(pf.s0_y));
  assign s1xs = $signed(TW'(pf.s1_x));
  assign s1ys = $signed(TW'(pf.s1_y));

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_pl_q       <= pf;
      f_far_q.l2_x <= s0xs - 28'sd2 * vx + pf.e0_x;
      f_far_q.l2_y <= s0ys - 28'sd2 * vy + pf.e0_y;
      f_far_q.l3_x <= s0xs - 28'sd2 * vx - pf.e0_x;
      f_far_q.l3_y <= s0ys - 28'sd2 * vy - pf.e0_y;
      f_far_q.r2_x <= s1xs + 28'sd2 * vx + pf.e1_x;
      f_far_q.r2_y <= s1ys + 28'sd2 * vy + pf.e1_y;
      f_far_q.r3_x <= s1xs + 28'sd2 * vx - pf.e1_x;
      f_far_q.r3_y <= s1ys + 28'sd2 * vy - pf.e1_y;
    end
  end

  rtsp_pair_out u_out (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (vld_q[NST-1]),
    .pl_i  (f_pl_q),
    .far_i (f_far_q),
    .take_o(take),
    .trap_o(trap_out)
  );
endmodule

// ----- hw/rtl/rtsp_checker.sv -----
// Port checker for the trapezoid block and its bind to the top level.
`timescale 1ns / 1ps
`include "rect_to_pair_search_trapezoids_defines.svh"
module rtsp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_side_i,
  input logic out_last_i,
  input logic out_degen_i
);
  `RTSP_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "output item dropped while stalled")
  `RTSP_ASSERT_NOW(a_last_side, out_valid_i, out_last_i == out_side_i, "last does not match side")
  `RTSP_ASSERT_NEXT(a_pair_next, out_valid_i && out_ready_i && !out_side_i, out_valid_i && out_side_i, "right item does not follow left")
  `RTSP_ASSERT_NEXT(a_pair_degen, out_valid_i && out_ready_i && !out_side_i, out_degen_i == $past(out_degen_i), "degenerate flag differs within pair")
endmodule

bind rect_to_pair_search_trapezoids rtsp_checker u_rtsp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(trap_out.valid),
  .out_ready_i(trap_out.ready),
  .out_side_i (trap_out.data.side),
  .out_last_i (trap_out.data.last),
  .out_degen_i(trap_out.data.degenerate)
);
